// ===== design/rrts_pkg.sv =====
// Package of the round-robin task scheduler.
// Holds command codes, walk modes, word types and controller/datapath structs.
// No dependencies.
package rrts_pkg;

  localparam int unsigned MaxTasksDefault = 8;

  typedef enum logic [2:0] {
    CMD_SCHEDULE = 3'd0,
    CMD_ADD      = 3'd1,
    CMD_EXIT     = 3'd2,
    CMD_WAIT     = 3'd3,
    CMD_NOTIFY   = 3'd4,
    CMD_SLEEP    = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_SCHED  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_UNLINK = 2'd2
  } mode_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [2:0]  task_id;
    logic [31:0] now_tick;
    logic [31:0] wake_tick;
    logic [31:0] wait_reason;
    logic [31:0] check_code;
    logic [31:0] expected_code;
  } in_word_t;

  typedef struct packed {
    logic [2:0] selected_task;
    logic       selected_idle;
    logic       accepted;
    logic [3:0] ready_count;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic start;
    logic walk;
    logic fin;
  } ctl_cmd_t;

  typedef struct packed {
    logic start_done;
    logic walk_done;
    logic out_busy;
  } ctl_stat_t;

endpackage

// ===== design/rrts_stream_if.sv =====
// Valid/ready stream interface carrying one word per handshake.
// The payload type is a parameter; used with the word types of rrts_pkg.
interface rrts_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/rrts_ctrl.sv =====
// Controller state machine of the task scheduler.
// Sequences load, decode, list walk and result write; uses rrts_pkg.
module rrts_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rrts_pkg::ctl_stat_t stat_i,
  output rrts_pkg::ctl_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_START = 4'b0010,
    S_WALK  = 4'b0100,
    S_FIN   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE) && !stat_i.out_busy;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load = 1'b1;
          state_d    = S_START;
        end
      end
      S_START: begin
        cmd_o.start = 1'b1;
        state_d     = stat_i.start_done ? S_FIN : S_WALK;
      end
      S_WALK: begin
        cmd_o.walk = 1'b1;
        if (stat_i.walk_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/rrts_datapath.sv =====
// Datapath of the task scheduler: ready list, task flags, counters and result register.
// Driven by rrts_ctrl through command and status structs; uses rrts_pkg.
module rrts_datapath #(
  parameter int unsigned MAX_TASKS = rrts_pkg::MaxTasksDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rrts_pkg::in_word_t   in_data_i,
  input  rrts_pkg::ctl_cmd_t   cmd_i,
  output rrts_pkg::ctl_stat_t  stat_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rrts_pkg::out_word_t  out_data_o
);

  localparam int unsigned SlotW = $clog2(MAX_TASKS + 1);
  localparam int unsigned IdxW  = $clog2(MAX_TASKS);
  localparam logic [SlotW-1:0] EndMark = SlotW'(MAX_TASKS);

  rrts_pkg::cmd_e    cmd_q;
  rrts_pkg::mode_e   mode_q, mode_d;
  logic [SlotW-1:0]  id_q, s_q, s_d, ns_q, ns_d, ptr_q, ptr_d, j_q, j_d;
  logic              idok_q, match_q, ok_q, ok_d;
  logic [31:0]       now_q, wtk_q;

  logic [SlotW-1:0]  next_q [MAX_TASKS];
  logic [SlotW-1:0]  next_d [MAX_TASKS];
  logic [31:0]       wake_q [MAX_TASKS];
  logic [31:0]       wake_d [MAX_TASKS];
  logic [MAX_TASKS-1:0] inl_q, inl_d, slp_q, slp_d, wtg_q, wtg_d;
  logic [SlotW-1:0]  head_q, head_d, cur_q, cur_d, total_q, total_d, wcnt_q, wcnt_d;

  logic                 out_valid_q, out_valid_d;
  rrts_pkg::out_word_t  out_q, out_d;

  logic [IdxW-1:0]   id_ix, cur_ix, ptr_ix, s_ix, c_ix, a_ix;
  logic [SlotW-1:0]  c_slot, ready_n, tgt;
  logic              cur_ok, do_append, do_unlink;
  logic              start_done, walk_done;
  logic [31:0]       diff;

  assign id_ix  = id_q[IdxW-1:0];
  assign cur_ix = cur_q[IdxW-1:0];
  assign ptr_ix = ptr_q[IdxW-1:0];
  assign s_ix   = s_q[IdxW-1:0];
  assign c_slot = (ptr_q >= EndMark) ? head_q : ptr_q;
  assign c_ix   = c_slot[IdxW-1:0];
  assign cur_ok = (cur_q < EndMark) && inl_q[cur_ix];
  assign ready_n = total_q - wcnt_q;
  assign diff   = now_q - wake_q[c_ix] - 32'd1;

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;
  assign stat_o.start_done = start_done;
  assign stat_o.walk_done  = walk_done;
  assign stat_o.out_busy   = out_valid_q && !out_ready_i;

  always_comb begin
    next_d      = next_q;
    wake_d      = wake_q;
    inl_d       = inl_q;
    slp_d       = slp_q;
    wtg_d       = wtg_q;
    head_d      = head_q;
    cur_d       = cur_q;
    total_d     = total_q;
    wcnt_d      = wcnt_q;
    mode_d      = mode_q;
    s_d         = s_q;
    ns_d        = ns_q;
    ptr_d       = ptr_q;
    j_d         = j_q;
    ok_d        = ok_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    start_done  = 1'b1;
    walk_done   = 1'b0;
    do_append   = 1'b0;
    do_unlink   = 1'b0;
    tgt         = id_q;
    a_ix        = id_ix;

    if (cmd_i.start) begin
      ok_d = 1'b0;
      unique case (cmd_q)
        rrts_pkg::CMD_SCHEDULE: begin
          ok_d   = 1'b1;
          ptr_d  = cur_ok ? next_q[cur_ix] : head_q;
          j_d    = '0;
          mode_d = rrts_pkg::MODE_SCHED;
          start_done = 1'b0;
        end
        rrts_pkg::CMD_ADD: begin
          if (idok_q && !inl_q[id_ix] && !wtg_q[id_ix] && (total_q < EndMark)) begin
            ok_d          = 1'b1;
            slp_d[id_ix]  = 1'b0;
            wake_d[id_ix] = '0;
            total_d       = total_q + 1'b1;
            do_append     = 1'b1;
          end
        end
        rrts_pkg::CMD_EXIT: begin
          if (idok_q && inl_q[id_ix]) begin
            ok_d         = 1'b1;
            slp_d[id_ix] = 1'b0;
            total_d      = total_q - 1'b1;
            do_unlink    = 1'b1;
          end
        end
        rrts_pkg::CMD_WAIT: begin
          if (match_q && cur_ok) begin
            ok_d          = 1'b1;
            wtg_d[cur_ix] = 1'b1;
            wcnt_d        = wcnt_q + 1'b1;
            do_unlink     = 1'b1;
            tgt           = cur_q;
            a_ix          = cur_ix;
          end
        end
        rrts_pkg::CMD_NOTIFY: begin
          if (idok_q && wtg_q[id_ix]) begin
            ok_d         = 1'b1;
            wtg_d[id_ix] = 1'b0;
            wcnt_d       = wcnt_q - 1'b1;
            do_append    = 1'b1;
          end
        end
        rrts_pkg::CMD_SLEEP: begin
          if (idok_q && inl_q[id_ix]) begin
            ok_d          = 1'b1;
            slp_d[id_ix]  = 1'b1;
            wake_d[id_ix] = wtk_q;
          end
        end
        default: ok_d = 1'b0;
      endcase

      s_d = tgt;
      if (do_append) begin
        next_d[a_ix] = EndMark;
        inl_d[a_ix]  = 1'b1;
        if (head_q >= EndMark) begin
          head_d = tgt;
        end else begin
          ptr_d  = head_q;
          mode_d = rrts_pkg::MODE_APPEND;
          start_done = 1'b0;
        end
      end
      if (do_unlink) begin
        if (head_q == tgt) begin
          head_d       = next_q[a_ix];
          next_d[a_ix] = EndMark;
          inl_d[a_ix]  = 1'b0;
        end else begin
          ns_d   = next_q[a_ix];
          ptr_d  = head_q;
          mode_d = rrts_pkg::MODE_UNLINK;
          start_done = 1'b0;
        end
      end
    end

    if (cmd_i.walk) begin
      case (mode_q)
        rrts_pkg::MODE_APPEND: begin
          if (ptr_q >= EndMark) begin
            walk_done = 1'b1;
          end else if (next_q[ptr_ix] >= EndMark) begin
            next_d[ptr_ix] = s_q;
            walk_done      = 1'b1;
          end else begin
            ptr_d = next_q[ptr_ix];
          end
        end
        rrts_pkg::MODE_UNLINK: begin
          if (ptr_q >= EndMark) begin
            next_d[s_ix] = EndMark;
            inl_d[s_ix]  = 1'b0;
            walk_done    = 1'b1;
          end else if (next_q[ptr_ix] == s_q) begin
            next_d[ptr_ix] = ns_q;
            next_d[s_ix]   = EndMark;
            inl_d[s_ix]    = 1'b0;
            walk_done      = 1'b1;
          end else begin
            ptr_d = next_q[ptr_ix];
          end
        end
        default: begin
          if ((j_q >= ready_n) || (c_slot >= EndMark)) begin
            cur_d     = EndMark;
            walk_done = 1'b1;
          end else if (!slp_q[c_ix]) begin
            cur_d     = c_slot;
            walk_done = 1'b1;
          end else if (diff < 32'h7FFF_FFFF) begin
            slp_d[c_ix]  = 1'b0;
            wake_d[c_ix] = '0;
            cur_d        = c_slot;
            walk_done    = 1'b1;
          end else begin
            ptr_d = next_q[c_ix];
            j_d   = j_q + 1'b1;
          end
        end
      endcase
    end

    if (cmd_i.fin) begin
      out_valid_d         = 1'b1;
      out_d.selected_idle = (cur_q >= EndMark);
      out_d.selected_task = (cur_q >= EndMark) ? 3'd0 : 3'(cur_q);
      out_d.accepted      = ok_q;
      out_d.ready_count   = 4'(ready_n);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        next_q[i] <= EndMark;
      end
      inl_q       <= '0;
      slp_q       <= '0;
      wtg_q       <= '0;
      head_q      <= EndMark;
      cur_q       <= EndMark;
      total_q     <= '0;
      wcnt_q      <= '0;
      mode_q      <= rrts_pkg::MODE_SCHED;
      out_valid_q <= 1'b0;
    end else begin
      next_q      <= next_d;
      inl_q       <= inl_d;
      slp_q       <= slp_d;
      wtg_q       <= wtg_d;
      head_q      <= head_d;
      cur_q       <= cur_d;
      total_q     <= total_d;
      wcnt_q      <= wcnt_d;
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wake_q <= wake_d;
    s_q    <= s_d;
    ns_q   <= ns_d;
    ptr_q  <= ptr_d;
    j_q    <= j_d;
    ok_q   <= ok_d;
    out_q  <= out_d;
    if (cmd_i.load) begin
      cmd_q   <= rrts_pkg::cmd_e'(in_data_i.command);
      id_q    <= SlotW'(in_data_i.task_id);
      idok_q  <= (32'(in_data_i.task_id) < MAX_TASKS);
      now_q   <= in_data_i.now_tick;
      wtk_q   <= in_data_i.wake_tick;
      match_q <= (in_data_i.check_code == in_data_i.expected_code);
    end
  end

endmodule

// ===== design/round_robin_task_scheduler.sv =====
// Top level of the round-robin task scheduler with sleep and wait.
// Instantiates rrts_ctrl and rrts_datapath; uses rrts_pkg and rrts_stream_if.
//
// Usage: command words arrive on in_i and one result word per command leaves
// on out_o. Both channels are valid/ready streams; a word moves at
// a rising edge with valid and ready high.
// A command word is taken when the block is idle and its result register is
// empty or being emptied in the same cycle. One word is in work at a time.
// After acceptance the command is decoded and applied, and the result word
// is then written; add, exit, wait, notify and sleep do so directly when no
// list walk is needed. Otherwise a list walk comes in between: one linked
// entry per cycle for schedule, tail append and predecessor search, plus one
// closing step when a schedule walk runs out of ready tasks.
// Reset empties the ready list, clears all sleep and wait flags, sets the
// current task to idle and zeroes the counters; it takes effect at once.
// While the receiver stalls, the result word holds in its register and the
// next command is not taken until the result has been delivered.
module round_robin_task_scheduler #(
  parameter int unsigned MAX_TASKS = rrts_pkg::MaxTasksDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  rrts_stream_if.sink   in_i,
  rrts_stream_if.source out_o
);

  rrts_pkg::ctl_cmd_t  ctl_cmd;
  rrts_pkg::ctl_stat_t ctl_stat;
  logic                in_ready;
  logic                out_valid;
  rrts_pkg::out_word_t out_data;

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_data;

  rrts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (ctl_stat),
    .cmd_o      (ctl_cmd)
  );

  rrts_datapath #(
    .MAX_TASKS (MAX_TASKS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_i.data),
    .cmd_i       (ctl_cmd),
    .stat_o      (ctl_stat),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_data)
  );

endmodule
